// File: hw/rtl/fsv_pkg.sv
// Shared types and constants for the format string validator.
`default_nettype none

package fsv_pkg;

   localparam int unsigned CHAR_W   = 8;
   localparam int unsigned COUNT_W  = 5;
   localparam int unsigned TYPES_W  = 31;
   localparam int unsigned SEEN_W   = 6;
   localparam int unsigned REASON_W = 3;
   localparam int unsigned PHASE_W  = 2;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 32;

   // Parser phases
   localparam logic [PHASE_W-1:0] PH_TEXT   = 2'd0;
   localparam logic [PHASE_W-1:0] PH_PCT    = 2'd1;
   localparam logic [PHASE_W-1:0] PH_DIGITS = 2'd2;
   localparam logic [PHASE_W-1:0] PH_DOLLAR = 2'd3;

   // Reject reasons
   localparam logic [REASON_W-1:0] RSN_OK        = 3'd0;
   localparam logic [REASON_W-1:0] RSN_BAD_CONV  = 3'd1;
   localparam logic [REASON_W-1:0] RSN_RANGE     = 3'd2;
   localparam logic [REASON_W-1:0] RSN_NO_DOLLAR = 3'd3;
   localparam logic [REASON_W-1:0] RSN_TYPE      = 3'd4;
   localparam logic [REASON_W-1:0] RSN_TOO_MANY  = 3'd5;
   localparam logic [REASON_W-1:0] RSN_MIXED     = 3'd6;
   localparam logic [REASON_W-1:0] RSN_HOLE      = 3'd7;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ARG_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ARG_TYPES = 2'd1;

   // Characters
   localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
   localparam logic [CHAR_W-1:0] CH_PERCENT = 8'h25;
   localparam logic [CHAR_W-1:0] CH_DOLLAR  = 8'h24;
   localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] CH_ONE     = 8'h31;
   localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
   localparam logic [CHAR_W-1:0] CH_D       = 8'h64;
   localparam logic [CHAR_W-1:0] CH_I       = 8'h69;
   localparam logic [CHAR_W-1:0] CH_S       = 8'h73;

   // Per-string parser state, apart from the position mask
   typedef struct packed {
      logic [PHASE_W-1:0]  phase;
      logic [COUNT_W-1:0]  index_accum;
      logic [SEEN_W-1:0]   sequential_seen;
      logic                positional_flag;
      logic                sequential_flag;
      logic [REASON_W-1:0] failure_code;
   } parse_state_type;

   // Verdict given on the terminator
   typedef struct packed {
      logic                terminal;
      logic                accepted;
      logic [REASON_W-1:0] reason;
   } verdict_type;

   localparam parse_state_type PARSE_CLEAR = '{
      phase:           PH_TEXT,
      index_accum:     '0,
      sequential_seen: '0,
      positional_flag: 1'b0,
      sequential_flag: 1'b0,
      failure_code:    RSN_OK
   };

endpackage

`default_nettype wire

// File: hw/rtl/fsv_if.sv
// Handshake interfaces for the request, response and register write channels.
`default_nettype none

interface fsv_req_if;
   import fsv_pkg::*;
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_code;
   modport source (output valid, output char_code, input ready);
   modport sink   (input valid, input char_code, output ready);
endinterface

interface fsv_rsp_if;
   import fsv_pkg::*;
   logic                valid;
   logic                ready;
   logic                accepted;
   logic [REASON_W-1:0] reject_reason;
   modport source (output valid, output accepted, output reject_reason, input ready);
   modport sink   (input valid, input accepted, input reject_reason, output ready);
endinterface

interface fsv_csr_if;
   import fsv_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  reg_index;
   logic [CSR_DATA_W-1:0] wdata;
   modport source (output valid, output reg_index, output wdata, input ready);
   modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/fsv_step.sv
// Next-state and verdict logic for one format string character.
`default_nettype none

module fsv_step
   import fsv_pkg::*;
#(
   parameter int unsigned MAX_ARGS = 31
) (
   input  wire parse_state_type      cur_state,
   input  wire logic [MAX_ARGS-1:0]  cur_mask,
   input  wire logic [CHAR_W-1:0]    char_code,
   input  wire logic [COUNT_W-1:0]   eff_count,
   input  wire logic [TYPES_W-1:0]   arg_types,
   output parse_state_type           nxt_state,
   output logic [MAX_ARGS-1:0]       nxt_mask,
   output verdict_type               verdict
);

   logic                is_digit;
   logic                is_nz_digit;
   logic                is_conv;
   logic [8:0]          digit_val;
   logic [SEEN_W-1:0]   seq_next;
   logic [COUNT_W-1:0]  seq_sel;
   logic [COUNT_W-1:0]  pos_sel;
   logic                seq_is_int;
   logic                pos_is_int;
   logic                seq_type_ok;
   logic                pos_type_ok;
   logic [MAX_ARGS:0]   mask_ext;
   logic                hole;
   parse_state_type     work;
   logic [MAX_ARGS-1:0] work_mask;
   logic [REASON_W-1:0] final_code;

   assign is_digit    = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
   assign is_nz_digit = (char_code >= CH_ONE) && (char_code <= CH_NINE);
   assign is_conv     = (char_code == CH_D) || (char_code == CH_I) || (char_code == CH_S);
   assign digit_val   = {4'b0, cur_state.index_accum} * 9'd10 + {5'b0, char_code[3:0]};

   assign seq_next    = cur_state.sequential_seen + SEEN_W'(1);
   assign seq_sel     = seq_next[COUNT_W-1:0] - COUNT_W'(1);
   assign pos_sel     = cur_state.index_accum - COUNT_W'(1);
   assign seq_is_int  = arg_types[seq_sel];
   assign pos_is_int  = arg_types[pos_sel];
   assign seq_type_ok = seq_is_int ? ((char_code == CH_D) || (char_code == CH_I))
                                   : (char_code == CH_S);
   assign pos_type_ok = pos_is_int ? ((char_code == CH_D) || (char_code == CH_I))
                                   : (char_code == CH_S);

   always_comb begin
      work      = cur_state;
      work_mask = cur_mask;
      if (cur_state.failure_code == RSN_OK) begin
         case (cur_state.phase)
            PH_TEXT: begin
               if (char_code == CH_PERCENT) begin
                  work.phase = PH_PCT;
               end
            end
            PH_PCT: begin
               if (char_code == CH_PERCENT) begin
                  work.phase = PH_TEXT;
               end else if (is_nz_digit) begin
                  if (COUNT_W'(char_code[3:0]) > eff_count) begin
                     work.failure_code = RSN_RANGE;
                     work.phase        = PH_TEXT;
                  end else begin
                     work.index_accum = COUNT_W'(char_code[3:0]);
                     work.phase       = PH_DIGITS;
                  end
               end else if (is_conv) begin
                  work.phase = PH_TEXT;
                  if (seq_next > {1'b0, eff_count}) begin
                     work.failure_code = RSN_TOO_MANY;
                  end else begin
                     work.sequential_seen = seq_next;
                     if (!seq_type_ok) begin
                        work.failure_code = RSN_TYPE;
                     end else begin
                        work.sequential_flag = 1'b1;
                        if (cur_state.positional_flag) begin
                           work.failure_code = RSN_MIXED;
                        end
                     end
                  end
               end else begin
                  work.failure_code = RSN_BAD_CONV;
                  work.phase        = PH_TEXT;
               end
            end
            PH_DIGITS: begin
               if (is_digit) begin
                  if (digit_val > {4'b0, eff_count}) begin
                     work.failure_code = RSN_RANGE;
                     work.phase        = PH_TEXT;
                  end else begin
                     work.index_accum = digit_val[COUNT_W-1:0];
                  end
               end else if (char_code == CH_DOLLAR) begin
                  work.phase = PH_DOLLAR;
               end else begin
                  work.failure_code = RSN_NO_DOLLAR;
                  work.phase        = PH_TEXT;
               end
            end
            default: begin
               work.phase = PH_TEXT;
               if ((cur_state.index_accum == '0) || (cur_state.index_accum > eff_count) ||
                   !pos_type_ok) begin
                  work.failure_code = RSN_TYPE;
               end else begin
                  work.positional_flag = 1'b1;
                  work_mask = cur_mask | (MAX_ARGS'(1) << pos_sel);
                  if (cur_state.sequential_flag) begin
                     work.failure_code = RSN_MIXED;
                  end
               end
            end
         endcase
      end
   end

   // Indices in use must form a run from 1 with no gap
   assign mask_ext   = {1'b0, work_mask};
   assign hole       = (mask_ext & (mask_ext + (MAX_ARGS+1)'(1))) != '0;
   assign final_code = ((work.failure_code == RSN_OK) && hole) ? RSN_HOLE
                                                                : work.failure_code;

   always_comb begin
      verdict.terminal = (char_code == CH_NUL);
      verdict.accepted = (final_code == RSN_OK);
      verdict.reason   = final_code;
      if (char_code == CH_NUL) begin
         nxt_state = PARSE_CLEAR;
         nxt_mask  = '0;
      end else begin
         nxt_state = work;
         nxt_mask  = work_mask;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/format_string_validator_unit.sv
// Top level of the format string validator: registers, handshakes and verdict output.
//
//  channel  | dir | payload                         | transfer when
//  ---------+-----+---------------------------------+------------------------
//  req_ch   | in  | char_code[7:0]                  | valid && ready
//  rsp_ch   | out | accepted, reject_reason[2:0]    | valid && ready
//  csr_ch   | in  | reg_index[1:0], wdata[31:0]     | valid && ready (ready = 1)
//
// One character per cycle: each transfer updates the parser registers in the
// same cycle through one level of next-state logic, so throughput is 1 item/cycle.
// A NUL's verdict is registered in the response register and shows on rsp_ch in the cycle after its transfer.
// Synchronous active-high reset clears the parser state, both registers and the
// response valid. req_ch stalls only while a verdict is held and rsp_ch is not ready.
`default_nettype none

module format_string_validator_unit
   import fsv_pkg::*;
#(
   parameter int unsigned MAX_ARGS = 31
) (
   input  wire logic clock,
   input  wire logic reset,
   fsv_req_if.sink   req_ch,
   fsv_rsp_if.source rsp_ch,
   fsv_csr_if.sink   csr_ch
);

   localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_ARGS);

   // Configuration registers
   logic [COUNT_W-1:0]  arg_count_ff, arg_count_in;
   logic [TYPES_W-1:0]  arg_types_ff, arg_types_in;

   // Per-string parser registers
   parse_state_type     state_ff, state_in;
   logic [MAX_ARGS-1:0] mask_ff, mask_in;

   // Response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_accepted_ff, rsp_accepted_in;
   logic [REASON_W-1:0] rsp_reason_ff, rsp_reason_in;

   logic                req_xfer;
   logic                csr_xfer;
   logic [COUNT_W-1:0]  eff_count;
   parse_state_type     step_state;
   logic [MAX_ARGS-1:0] step_mask;
   verdict_type         verdict;

   // Accept a character unless a verdict is held and cannot drain this cycle
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;
   assign csr_xfer     = csr_ch.valid;

   // Clamp the argument count to what the mask can hold
   assign eff_count = (arg_count_ff > MAX_COUNT) ? MAX_COUNT : arg_count_ff;

   fsv_step #(
      .MAX_ARGS (MAX_ARGS)
   ) u_step (
      .cur_state (state_ff),
      .cur_mask  (mask_ff),
      .char_code (req_ch.char_code),
      .eff_count (eff_count),
      .arg_types (arg_types_ff),
      .nxt_state (step_state),
      .nxt_mask  (step_mask),
      .verdict   (verdict)
   );

   always_comb begin
      // Register writes; unknown indexes drop
      arg_count_in = arg_count_ff;
      arg_types_in = arg_types_ff;
      if (csr_xfer) begin
         case (csr_ch.reg_index)
            CSR_ARG_COUNT: arg_count_in = csr_ch.wdata[COUNT_W-1:0];
            CSR_ARG_TYPES: arg_types_in = csr_ch.wdata[TYPES_W-1:0];
            default: ;
         endcase
      end

      // Advance the parser only on a transfer
      state_in = state_ff;
      mask_in  = mask_ff;
      if (req_xfer) begin
         state_in = step_state;
         mask_in  = step_mask;
      end

      // Load a verdict on the terminator, drop it once taken
      rsp_valid_in    = rsp_valid_ff;
      rsp_accepted_in = rsp_accepted_ff;
      rsp_reason_in   = rsp_reason_ff;
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_xfer && verdict.terminal) begin
         rsp_valid_in    = 1'b1;
         rsp_accepted_in = verdict.accepted;
         rsp_reason_in   = verdict.reason;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         arg_count_ff <= '0;
         arg_types_ff <= '0;
         state_ff     <= PARSE_CLEAR;
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         arg_count_ff <= arg_count_in;
         arg_types_ff <= arg_types_in;
         state_ff     <= state_in;
         mask_ff      <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload holds without reset
   always_ff @(posedge clock) begin
      rsp_accepted_ff <= rsp_accepted_in;
      rsp_reason_ff   <= rsp_reason_in;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.accepted      = rsp_accepted_ff;
   assign rsp_ch.reject_reason = rsp_reason_ff;

endmodule

`default_nettype wire

// File: tb/sv/tb_format_string_validator_unit.sv
// Self-checking bench: format strings streamed into the validator, verdicts checked per string.
`default_nettype none

module tb_format_string_validator_unit;
   import fsv_pkg::*;

   localparam int unsigned ARG_LIMIT     = 31;    // matches the block's MAX_ARGS default
   localparam int unsigned ITEM_TARGET   = 1700;  // characters to push in all, directed part included
   localparam int unsigned PHASE_ITEMS   = 150;   // characters per configuration setting
   localparam int unsigned IDLE_PERCENT  = 34;
   localparam int unsigned HOLD_CYCLES   = 160;   // long response back-pressure window
   localparam int unsigned STALL_LIMIT   = 2000;  // cycles without any transfer
   localparam int unsigned SETTLE_CYCLES = 3;
   localparam int unsigned SQUEEZE_LINES = 30;

   // Register indexes past the defined list; writes there must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 2'd3;

   localparam logic [CHAR_W-1:0] CH_TWO   = CH_ONE + 8'd1;
   localparam logic [CHAR_W-1:0] CH_THREE = CH_ONE + 8'd2;
   localparam logic [CHAR_W-1:0] CH_LOW_Z = 8'h7A;

   typedef struct packed {
      logic                accepted;
      logic [REASON_W-1:0] reason;
   } string_verdict_type;

   // Predicts the verdict of each string and checks what the block returns.
   class verdict_scoreboard;
      logic [COUNT_W-1:0]  arg_count;
      logic [TYPES_W-1:0]  arg_types;
      logic [PHASE_W-1:0]  phase;
      int unsigned         index_accum;
      int unsigned         seq_used;
      logic [TYPES_W-1:0]  pos_used;
      bit                  pos_flag;
      bit                  seq_flag;
      logic [REASON_W-1:0] failure;
      string_verdict_type  pending[$];
      int unsigned         mismatches;

      function new();
         arg_count  = '0;
         arg_types  = '0;
         mismatches = 0;
         clear_string();
      endfunction

      function void clear_string();
         phase       = PH_TEXT;
         index_accum = 0;
         seq_used    = 0;
         pos_used    = '0;
         pos_flag    = 1'b0;
         seq_flag    = 1'b0;
         failure     = RSN_OK;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_ARG_COUNT) begin
            arg_count = data[COUNT_W-1:0];
         end else if (idx == CSR_ARG_TYPES) begin
            arg_types = data[TYPES_W-1:0];
         end
      endfunction

      // arg is 1-based and already known to be in range
      function bit type_fits(int unsigned arg, logic [CHAR_W-1:0] c);
         if (arg_types[arg-1]) return (c == CH_D) || (c == CH_I);
         return c == CH_S;
      endfunction

      function void latch(logic [REASON_W-1:0] code);
         failure = code;
         phase   = PH_TEXT;
      endfunction

      function void check_mixed();
         if (pos_flag && seq_flag) latch(RSN_MIXED);
      endfunction

      function void note_char(logic [CHAR_W-1:0] c);
         int unsigned        n;
         int unsigned        v;
         int unsigned        k;
         int unsigned        m;
         string_verdict_type result;
         n = (arg_count > ARG_LIMIT) ? ARG_LIMIT : 32'(arg_count);
         if (failure == RSN_OK) begin
            case (phase)
               PH_TEXT: if (c == CH_PERCENT) phase = PH_PCT;
               PH_PCT: begin
                  if (c == CH_PERCENT) begin
                     phase = PH_TEXT;
                  end else if (c >= CH_ONE && c <= CH_NINE) begin
                     v = 32'(c - CH_ZERO);
                     if (v > n) begin
                        latch(RSN_RANGE);
                     end else begin
                        index_accum = v;
                        phase       = PH_DIGITS;
                     end
                  end else if (c == CH_D || c == CH_I || c == CH_S) begin
                     k     = seq_used + 1;
                     phase = PH_TEXT;
                     if (k > n) begin
                        latch(RSN_TOO_MANY);
                     end else begin
                        seq_used = k;
                        if (!type_fits(k, c)) begin
                           latch(RSN_TYPE);
                        end else begin
                           seq_flag = 1'b1;
                           check_mixed();
                        end
                     end
                  end else begin
                     latch(RSN_BAD_CONV);
                  end
               end
               PH_DIGITS: begin
                  if (c >= CH_ZERO && c <= CH_NINE) begin
                     v = index_accum * 10 + 32'(c - CH_ZERO);
                     if (v > n) latch(RSN_RANGE);
                     else index_accum = v;
                  end else if (c == CH_DOLLAR) begin
                     phase = PH_DOLLAR;
                  end else begin
                     latch(RSN_NO_DOLLAR);
                  end
               end
               default: begin
                  phase = PH_TEXT;
                  if (index_accum == 0 || index_accum > n || !type_fits(index_accum, c)) begin
                     latch(RSN_TYPE);
                  end else begin
                     pos_flag                = 1'b1;
                     pos_used[index_accum-1] = 1'b1;
                     check_mixed();
                  end
               end
            endcase
         end
         if (c == CH_NUL) begin
            // indices must run 1..K: the used mask has to be all ones from bit 0 up
            m = 32'(pos_used);
            if (failure == RSN_OK && (m & (m + 1)) != 0) failure = RSN_HOLE;
            result.accepted = (failure == RSN_OK);
            result.reason   = failure;
            pending.push_back(result);
            clear_string();
         end
      endfunction

      task report_mismatch(string what);
         $display("MISMATCH @%0t: %s", $time, what);
         mismatches++;
      endtask

      task check_verdict(logic acc, logic [REASON_W-1:0] reason);
         string_verdict_type want;
         if (pending.size() == 0) begin
            report_mismatch($sformatf("verdict with no string pending: accepted=%0b reason=%0d",
                                      acc, reason));
            return;
         end
         want = pending.pop_front();
         if (acc !== want.accepted)
            report_mismatch($sformatf("accepted %0b, want %0b", acc, want.accepted));
         if (reason !== want.reason)
            report_mismatch($sformatf("reject_reason %0d, want %0d", reason, want.reason));
      endtask
   endclass

   logic clock;
   logic reset;

   fsv_req_if req_ch ();
   fsv_rsp_if rsp_ch ();
   fsv_csr_if csr_ch ();

   format_string_validator_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   verdict_scoreboard  verdicts = new();

   logic [CHAR_W-1:0]  fmt_chars[$];     // string under construction, NUL not included
   logic [COUNT_W-1:0] cur_count;        // generator's view of the programmed registers
   logic [TYPES_W-1:0] cur_types;
   bit                 steady;           // both sides stop idling while set
   int unsigned        hold_requests;    // bumped by the sender, one long hold each
   int unsigned        hold_served;      // owned by the response process
   int unsigned        chars_sent;
   int unsigned        stall_cycles;
   int unsigned        phase_no;

   // Clock: period of 4 time units.
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Response side: random back-pressure, plus a long hold on request.
   initial begin
      hold_served = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_served != hold_requests) begin
            // hold ready low long enough for a verdict to stick and block the input
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_served++;
         end
         rsp_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   // Monitor: every transfer is sampled here with pre-edge values, so the
   // predictor sees register writes, characters and verdicts in bus order.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_ch.valid && csr_ch.ready)
            verdicts.write_register(csr_ch.reg_index, csr_ch.wdata);
         if (req_ch.valid && req_ch.ready)
            verdicts.note_char(req_ch.char_code);
         if (rsp_ch.valid && rsp_ch.ready)
            verdicts.check_verdict(rsp_ch.accepted, rsp_ch.reject_reason);
      end
   end

   // Watchdog: drop the run if no channel transfers for too long.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // String generation
   // ---------------------------------------------------------------------

   // Any byte that is plain text: not NUL, not '%'.
   function automatic logic [CHAR_W-1:0] text_byte();
      logic [CHAR_W-1:0] b;
      do b = 8'($urandom_range(1, 255)); while (b == CH_PERCENT);
      return b;
   endfunction

   function automatic logic [CHAR_W-1:0] any_letter();
      case ($urandom_range(0, 2))
         0:       return CH_D;
         1:       return CH_I;
         default: return CH_S;
      endcase
   endfunction

   // Conversion letter for argument arg (1..count); fits picks a matching letter.
   function automatic logic [CHAR_W-1:0] letter_for(int unsigned arg, bit fits);
      if (cur_types[arg-1] == fits) return $urandom_range(0, 1) ? CH_D : CH_I;
      return CH_S;
   endfunction

   // Bytes that tend to drive the parser into its corners.
   function automatic logic [CHAR_W-1:0] noise_byte();
      case ($urandom_range(0, 5))
         0:       return CH_PERCENT;
         1:       return CH_DOLLAR;
         2:       return CH_ZERO + 8'($urandom_range(0, 9));
         3:       return any_letter();
         default: return text_byte();
      endcase
   endfunction

   function automatic void push_index(int unsigned v);
      if (v >= 10) fmt_chars.push_back(CH_ZERO + 8'(v / 10));
      fmt_chars.push_back(CH_ZERO + 8'(v % 10));
   endfunction

   // Plain text, sometimes with an escaped percent.
   function automatic void add_gap();
      repeat ($urandom_range(0, 2)) fmt_chars.push_back(text_byte());
      if ($urandom_range(0, 7) == 0) begin
         fmt_chars.push_back(CH_PERCENT);
         fmt_chars.push_back(CH_PERCENT);
      end
   endfunction

   // One "%N$x", mostly well formed; a few are broken on purpose.
   function automatic void add_positional_conv(int unsigned arg);
      int unsigned n;
      n = cur_count;
      fmt_chars.push_back(CH_PERCENT);
      case ($urandom_range(0, 39))
         0: begin   // index above the count
            push_index(n + $urandom_range(1, 9));
            fmt_chars.push_back(CH_DOLLAR);
            fmt_chars.push_back(any_letter());
         end
         1: begin   // leading zero
            fmt_chars.push_back(CH_ZERO);
            push_index(arg);
            fmt_chars.push_back(CH_DOLLAR);
         end
         2: begin   // missing dollar
            push_index(arg);
            fmt_chars.push_back(any_letter());
         end
         3: begin   // junk after the dollar
            push_index(arg);
            fmt_chars.push_back(CH_DOLLAR);
            fmt_chars.push_back(noise_byte());
         end
         default: begin
            push_index(arg);
            fmt_chars.push_back(CH_DOLLAR);
            fmt_chars.push_back(arg <= n ? letter_for(arg, $urandom_range(0, 9) != 0)
                                         : any_letter());
         end
      endcase
   endfunction

   // Positional string: indices 1..K shuffled, now and then a hole, a repeat
   // or a trailing sequential conversion that mixes the two styles.
   function automatic void add_positional();
      int unsigned n;
      int unsigned k;
      int unsigned j;
      int unsigned t;
      int unsigned tmp;
      int unsigned order[$];
      n = cur_count;
      if (n == 0) k = 1;
      else if ($urandom_range(0, 9) == 0) k = n;
      else k = $urandom_range(1, (n > 6) ? 6 : n);
      for (j = 1; j <= k; j++) order.push_back(j);
      for (j = k - 1; j > 0; j--) begin
         t        = $urandom_range(0, j);
         tmp      = order[j];
         order[j] = order[t];
         order[t] = tmp;
      end
      if (k > 1 && $urandom_range(0, 9) == 0) order.delete($urandom_range(0, k - 1));
      if ($urandom_range(0, 9) == 0) order.push_back(order[0]);
      for (j = 0; j < order.size(); j++) begin
         add_gap();
         add_positional_conv(order[j]);
      end
      if ($urandom_range(0, 11) == 0) begin
         fmt_chars.push_back(CH_PERCENT);
         fmt_chars.push_back(any_letter());
      end
      add_gap();
   endfunction

   // Sequential string: up to count conversions, sometimes one too many, and
   // now and then a positional one mixed in.
   function automatic void add_sequential();
      int unsigned n;
      int unsigned k;
      int unsigned j;
      n = cur_count;
      if ($urandom_range(0, 9) == 0) k = n + $urandom_range(0, 1);
      else k = $urandom_range(0, (n > 6) ? 6 : n);
      for (j = 1; j <= k; j++) begin
         add_gap();
         fmt_chars.push_back(CH_PERCENT);
         fmt_chars.push_back(j <= n ? letter_for(j, $urandom_range(0, 9) != 0) : any_letter());
      end
      if ($urandom_range(0, 11) == 0) begin
         fmt_chars.push_back(CH_PERCENT);
         fmt_chars.push_back(CH_ONE);
         fmt_chars.push_back(CH_DOLLAR);
         fmt_chars.push_back(CH_D);
      end
      add_gap();
   endfunction

   function automatic void add_noise();
      repeat ($urandom_range(1, 10)) fmt_chars.push_back(noise_byte());
   endfunction

   // ---------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------

   // Offer one character and hold it until the block takes it. Each idle
   // cycle is drawn on its own, so about a third of the cycles stay empty.
   task automatic send_char(input logic [CHAR_W-1:0] c);
      while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.char_code <= c;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      chars_sent++;
   endtask

   // Send the built string and its terminator, then clear the buffer.
   task automatic send_line();
      while (fmt_chars.size() != 0) send_char(fmt_chars.pop_front());
      send_char(CH_NUL);
   endtask

   // One register write; valid is left high for back-to-back writes.
   task automatic csr_transfer(input logic [CSR_IDX_W-1:0] idx,
                               input logic [CSR_DATA_W-1:0] data);
      csr_ch.valid     <= 1'b1;
      csr_ch.reg_index <= idx;
      csr_ch.wdata     <= data;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
   endtask

   // Program both registers, with junk in the unused upper bits, and poke a
   // spare index that the block has to ignore.
   task automatic program_args(input logic [COUNT_W-1:0] count,
                               input logic [TYPES_W-1:0] types);
      logic [CSR_DATA_W-1:0] word;
      word = $urandom;
      csr_transfer(CSR_ARG_COUNT, {word[CSR_DATA_W-1:COUNT_W], count});
      word = $urandom;
      csr_transfer(CSR_ARG_TYPES, {word[CSR_DATA_W-1:TYPES_W], types});
      csr_transfer($urandom_range(0, 1) ? CSR_SPARE_LO : CSR_SPARE_HI, $urandom);
      csr_ch.valid <= 1'b0;
      cur_count = count;
      cur_types = types;
   endtask

   // Stop offering, wait for every verdict, then let the pipeline settle.
   // Wait for a clock edge first so the monitor has noted the last terminator.
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (verdicts.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_strings(input int unsigned budget);
      int unsigned start;
      int unsigned pick;
      start = chars_sent;
      while (chars_sent - start < budget) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) add_sequential();
         else if (pick < 80) add_positional();
         else add_noise();
         send_line();
      end
   endtask

   // Ask for a long response hold and keep short strings coming, so a held
   // verdict backs up into the input channel.
   task automatic squeeze_output();
      hold_requests++;
      repeat (SQUEEZE_LINES) begin
         add_sequential();
         send_line();
      end
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.char_code <= CH_NUL;
      csr_ch.valid     <= 1'b0;
      csr_ch.reg_index <= CSR_ARG_COUNT;
      csr_ch.wdata     <= '0;
      steady        = 1'b0;
      hold_requests = 0;
      chars_sent    = 0;
      cur_count     = '0;
      cur_types     = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part: three arguments, int / string / int.
      program_args(5'd3, 31'd5);
      fmt_chars = '{8'hFF, CH_PERCENT, CH_PERCENT};              // text and escaped percent
      send_line();
      fmt_chars = '{CH_PERCENT};                                 // string ends after percent
      send_line();
      fmt_chars = '{CH_PERCENT, CH_TWO};                         // ends inside the index
      send_line();
      fmt_chars = '{CH_PERCENT, CH_ONE, CH_DOLLAR};              // ends right after dollar
      send_line();
      fmt_chars = '{CH_PERCENT, CH_ONE, CH_DOLLAR, CH_S};        // wrong letter after dollar
      send_line();
      fmt_chars = '{CH_PERCENT, CH_ZERO, CH_LOW_Z};              // leading zero, tail ignored
      send_line();
      fmt_chars = '{CH_PERCENT, CH_NINE};                        // index above the count
      send_line();
      fmt_chars = '{CH_PERCENT, CH_TWO, CH_DOLLAR, CH_S, CH_PERCENT, CH_D};  // mixed styles
      send_line();
      fmt_chars = '{CH_PERCENT, CH_THREE, CH_DOLLAR, CH_I};      // hole below index three
      send_line();
      drain();

      // Random part: one register setting per phase, extremes first.
      phase_no = 0;
      while (chars_sent < ITEM_TARGET) begin
         case (phase_no)
            0:       program_args(5'd0, '0);
            1:       program_args(5'd31, '1);
            2:       program_args(5'd31, '0);
            3:       program_args(5'd1, 31'd1);
            default: program_args(5'($urandom_range(0, 31)), 31'($urandom));
         endcase
         steady = (phase_no == 4);
         if (phase_no == 5) squeeze_output();
         run_strings(PHASE_ITEMS);
         drain();
         phase_no++;
      end
      steady = 1'b0;

      // Every terminator sent must have come back as a verdict.
      if (verdicts.pending.size() != 0)
         verdicts.report_mismatch($sformatf("%0d verdicts never returned",
                                            verdicts.pending.size()));

      if (verdicts.mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

`default_nettype wire
